@@ design/luhn_pkg.sv @@
// Shared types, widths and constants for the Luhn card number check unit.
package luhn_pkg;

   // Field widths.
   localparam int CARD_WIDTH    = 54;
   localparam int COUNT_WIDTH   = 5;
   localparam int VERDICT_WIDTH = 2;
   localparam int DIGIT_WIDTH   = 4;
   localparam int LEAD2_WIDTH   = 7;

   // The divider works on one half of the padded card value at a time.
   localparam int SLICE_WIDTH   = 28;

   // Reciprocal of ten for a 32-bit dividend: multiply, then drop 35 bits.
   localparam logic [63:0] RECIP_TEN   = 64'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   // Largest card number that may be accepted as valid.
   localparam logic [CARD_WIDTH-1:0] CARD_MAX = 54'd9999999999999999;

   // Verdict codes.
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_INVALID = 2'd0;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_BRAND_1 = 2'd1;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_BRAND_2 = 2'd2;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_BRAND_3 = 2'd3;

   // Lengths and prefixes used by the classifier.
   localparam logic [COUNT_WIDTH-1:0] LEN_LONG   = 5'd16;
   localparam logic [COUNT_WIDTH-1:0] LEN_SHORT  = 5'd13;
   localparam logic [COUNT_WIDTH-1:0] LEN_MIDDLE = 5'd15;
   localparam logic [DIGIT_WIDTH-1:0] LEAD_FOUR  = 4'd4;
   localparam logic [LEAD2_WIDTH-1:0] PAIR_LOW   = 7'd51;
   localparam logic [LEAD2_WIDTH-1:0] PAIR_HIGH  = 7'd55;
   localparam logic [LEAD2_WIDTH-1:0] PAIR_A     = 7'd34;
   localparam logic [LEAD2_WIDTH-1:0] PAIR_B     = 7'd37;

   typedef logic [CARD_WIDTH-1:0]  card_type;
   typedef logic [DIGIT_WIDTH-1:0] digit_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   // Summary of one card number handed to the classifier.
   typedef struct packed {
      logic      in_range;
      logic      sum_ok;
      count_type count;
      digit_type top;
      digit_type next;
   } class_info_type;

endpackage

@@ design/luhn_card_number_check_unit.sv @@
// Top level of the Luhn card number check unit: sequencer and result register.
//
// A transaction is started by raising start while busy is low; req_card_value
// is captured at that clock edge and busy rises on the next cycle.
// The shared divide-by-ten unit works on the captured value in two halves, so
// each decimal digit, least significant first, is formed in ST_HIGH then ST_LOW;
// as each digit comes out the Luhn total (kept modulo ten), the digit count and
// the two leading digits are updated.
// When no digits remain the verdict and digit count are registered and shown
// on rsp_verdict and rsp_digit_count for exactly one cycle with rsp_valid.
// Busy falls in the strobe cycle, so a new transaction may be accepted at its
// end. A new transaction is not taken before the last is done, as the single
// divide-by-ten unit is used for both halves of every digit.
// The receiver cannot stall: the result is taken in its strobe cycle.
// Synchronous reset returns the sequencer to idle and drops rsp_valid; a
// transaction in progress is discarded.
module luhn_card_number_check_unit
   import luhn_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [CARD_WIDTH-1:0]    req_card_value,
   output logic                     rsp_valid,
   output logic [VERDICT_WIDTH-1:0] rsp_verdict,
   output logic [COUNT_WIDTH-1:0]   rsp_digit_count
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HIGH,
      ST_LOW
   } state_type;

   state_type                state_ff, state_in;
   card_type                 rest_ff, rest_in;
   digit_type                carry_ff, carry_in;
   logic                     range_ff, range_in;
   count_type                count_ff, count_in;
   digit_type                sum_ff, sum_in;
   digit_type                top_ff, top_in;
   digit_type                next_ff, next_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_WIDTH-1:0] rsp_verdict_ff, rsp_verdict_in;
   count_type                rsp_count_ff, rsp_count_in;

   digit_type                div_rem;
   logic [SLICE_WIDTH-1:0]   div_slice;
   logic [SLICE_WIDTH-1:0]   quotient;
   digit_type                digit;
   logic [DIGIT_WIDTH:0]     addend;
   logic [DIGIT_WIDTH:0]     total;
   class_info_type           info;
   logic [VERDICT_WIDTH-1:0] verdict;

   // The upper half is divided first; the lower half then takes its remainder.
   always_comb begin
      if (state_ff == ST_LOW) begin
         div_rem   = carry_ff;
         div_slice = rest_ff[SLICE_WIDTH-1:0];
      end else begin
         div_rem   = '0;
         div_slice = {{(2*SLICE_WIDTH-CARD_WIDTH){1'b0}},
                      rest_ff[CARD_WIDTH-1:SLICE_WIDTH]};
      end
   end

   // Shared divider working on the remaining value.
   luhn_div10 u_div10 (
      .upper_rem (div_rem),
      .slice     (div_slice),
      .quotient  (quotient),
      .remainder (digit)
   );

   // Doubled digits at odd positions fold their two decimal digits together.
   always_comb begin
      if (count_ff[0]) begin
         if (digit >= 4'd5) begin
            addend = {digit, 1'b0} - 5'd9;
         end else begin
            addend = {digit, 1'b0};
         end
      end else begin
         addend = {1'b0, digit};
      end
      total = {1'b0, sum_ff} + addend;
      if (total >= 5'd10) begin
         total = total - 5'd10;
      end
   end

   assign info.in_range = range_ff;
   assign info.sum_ok   = (sum_ff == '0);
   assign info.count    = count_ff;
   assign info.top      = top_ff;
   assign info.next     = next_ff;

   luhn_classify u_classify (
      .info    (info),
      .verdict (verdict)
   );

   // Sequencer next-state logic.
   always_comb begin
      state_in       = state_ff;
      rest_in        = rest_ff;
      carry_in       = carry_ff;
      range_in       = range_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      top_in         = top_ff;
      next_in        = next_ff;
      rsp_valid_in   = 1'b0;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_count_in   = rsp_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rest_in  = req_card_value;
               carry_in = '0;
               range_in = (req_card_value <= CARD_MAX);
               count_in = '0;
               sum_in   = '0;
               top_in   = '0;
               next_in  = '0;
               state_in = ST_HIGH;
            end
         end
         ST_HIGH: begin
            if (rest_ff != '0) begin
               rest_in  = {quotient[CARD_WIDTH-SLICE_WIDTH-1:0],
                           rest_ff[SLICE_WIDTH-1:0]};
               carry_in = digit;
               state_in = ST_LOW;
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict;
               rsp_count_in   = count_ff;
               state_in       = ST_IDLE;
            end
         end
         ST_LOW: begin
            rest_in  = {rest_ff[CARD_WIDTH-1:SLICE_WIDTH], quotient};
            count_in = count_ff + 5'd1;
            sum_in   = total[DIGIT_WIDTH-1:0];
            next_in  = top_ff;
            top_in   = digit;
            state_in = ST_HIGH;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rest_ff        <= rest_in;
      carry_ff       <= carry_in;
      range_ff       <= range_in;
      count_ff       <= count_in;
      sum_ff         <= sum_in;
      top_ff         <= top_in;
      next_ff        <= next_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_digit_count = rsp_count_ff;

endmodule

@@ design/luhn_div10.sv @@
// Divide-by-ten unit: divides one 28-bit slice, with the remainder of the slice above, by ten.
module luhn_div10
   import luhn_pkg::*;
(
   input  digit_type              upper_rem,
   input  logic [SLICE_WIDTH-1:0] slice,
   output logic [SLICE_WIDTH-1:0] quotient,
   output digit_type              remainder
);

   logic [SLICE_WIDTH+DIGIT_WIDTH-1:0] dividend;
   logic [63:0]                        prod;
   logic [SLICE_WIDTH+DIGIT_WIDTH-1:0] back;

   // The dividend is below ten times two to the 28, so the reciprocal
   // multiply followed by a shift of 35 gives the exact quotient.
   assign dividend  = {upper_rem, slice};
   assign prod      = 64'(dividend) * RECIP_TEN;
   assign quotient  = SLICE_WIDTH'(prod >> RECIP_SHIFT);

   // Remainder is what is left after taking ten times the quotient away.
   assign back      = {1'b0, quotient, 3'b000} + {3'b000, quotient, 1'b0};
   assign remainder = 4'(dividend - back);

endmodule

@@ design/luhn_classify.sv @@
// Verdict from digit count, leading digits, range and Luhn total.
module luhn_classify
   import luhn_pkg::*;
(
   input  class_info_type            info,
   output logic [VERDICT_WIDTH-1:0] verdict
);

   logic [LEAD2_WIDTH-1:0] lead2;

   // Leading pair as a two-digit number.
   assign lead2 = {info.top, 3'b000} + {2'b00, info.top, 1'b0} + {3'b000, info.next};

   always_comb begin
      verdict = VERDICT_INVALID;
      if (info.in_range && info.sum_ok && (info.count != '0)) begin
         if (info.count == LEN_LONG) begin
            if (info.top == LEAD_FOUR) begin
               verdict = VERDICT_BRAND_1;
            end else if ((lead2 >= PAIR_LOW) && (lead2 <= PAIR_HIGH)) begin
               verdict = VERDICT_BRAND_2;
            end
         end else if ((info.count == LEN_SHORT) && (info.top == LEAD_FOUR)) begin
            verdict = VERDICT_BRAND_1;
         end else if ((info.count == LEN_MIDDLE) &&
                      ((lead2 == PAIR_A) || (lead2 == PAIR_B))) begin
            verdict = VERDICT_BRAND_3;
         end
      end
   end

endmodule
